>>> design/tadpcm_pkg.sv
// shared types and constants for the two-tap adpcm block decoder
package tadpcm_pkg;

   // command word passed from the front end to the decode engine
   typedef struct packed {
      logic        is_clear;   // header word that carries a restart: clear histories only
      logic [7:0]  data_byte;  // two packed nibbles, high nibble first
      logic [15:0] scale;      // block scale in force for this word
   } cmd_type;

   // command queue depth and pointer widths
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // block layout
   localparam logic [7:0] POS_SCALE_HI    = 8'd0;
   localparam logic [7:0] POS_SCALE_LO    = 8'd1;
   localparam logic [7:0] POS_FIRST_DATA  = 8'd2;
   localparam logic [7:0] MIN_BLOCK_BYTES = 8'd3;

   // register map, word index into the csr space
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] CSR_COEFF_A       = 3'd0;
   localparam logic [2:0] CSR_COEFF_B       = 3'd1;
   localparam logic [2:0] CSR_BLOCK_BYTES   = 3'd2;
   localparam logic [2:0] CSR_CHANNEL_COUNT = 3'd3;
   localparam logic [2:0] CSR_VOLUME        = 3'd4;

   // register reset values
   localparam logic [13:0] COEFF_A_RST       = 14'd0;
   localparam logic [12:0] COEFF_B_RST       = 13'd0;
   localparam logic [7:0]  BLOCK_BYTES_RST   = 8'd18;
   localparam logic [1:0]  CHANNEL_COUNT_RST = 2'd1;
   localparam logic [6:0]  VOLUME_RST        = 7'd127;

   // sample arithmetic
   localparam int PRED_SHIFT = 12;
   localparam int VOL_SHIFT  = 7;
   localparam logic signed [31:0] SAMPLE_MAX = 32'sd32767;
   localparam logic signed [31:0] SAMPLE_MIN = -32'sd32768;

endpackage

>>> design/two_tap_adpcm_block_decoder_top.sv
// Two-tap ADPCM block decoder: scale header bytes are taken by the front end and give no word.
// A data byte gives two sample words; the serial loop in the decode engine (pop, then product,
// sum and clamp, volume product, output per nibble) finishes one data byte before it pops the
// next, and waits in the output step while the output register is stalled.
// Synchronous active-high reset clears histories, block position, channel and registers
// (coeff_a 0, coeff_b 0, block_bytes 18, channel_count 1, volume 127).
module two_tap_adpcm_block_decoder_top #(
   parameter int MAX_CHANNELS = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [7:0] data_byte
   input  logic [0:0]                            req_tuser,   // [0] restart
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [15:0]                           rsp_tdata,   // [15:0] sample
   output logic [0:0]                            rsp_tuser,   // [0] channel
   output logic                                  rsp_tlast,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tadpcm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import tadpcm_pkg::*;

   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int QW   = $bits(cmd_type) + CH_W;

   logic [13:0] coeff_a_ff;
   logic [12:0] coeff_b_ff;
   logic [7:0]  block_bytes_ff;
   logic [1:0]  channel_count_ff;
   logic [6:0]  volume_ff;

   logic [2:0]  csr_index;
   logic        csr_write;

   logic            q_full;
   logic            q_push;
   cmd_type         push_cmd;
   logic [CH_W-1:0] push_chan;
   logic            q_valid;
   logic            q_pop;
   logic [QW-1:0]   q_rd_data;
   cmd_type         pop_cmd;
   logic [CH_W-1:0] pop_chan;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_a_ff       <= COEFF_A_RST;
         coeff_b_ff       <= COEFF_B_RST;
         block_bytes_ff   <= BLOCK_BYTES_RST;
         channel_count_ff <= CHANNEL_COUNT_RST;
         volume_ff        <= VOLUME_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_COEFF_A:       coeff_a_ff       <= csr_pwdata[13:0];
            CSR_COEFF_B:       coeff_b_ff       <= csr_pwdata[12:0];
            CSR_BLOCK_BYTES:   block_bytes_ff   <= csr_pwdata[7:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_pwdata[1:0];
            CSR_VOLUME:        volume_ff        <= csr_pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         CSR_COEFF_A:       csr_prdata = 32'(coeff_a_ff);
         CSR_COEFF_B:       csr_prdata = 32'(coeff_b_ff);
         CSR_BLOCK_BYTES:   csr_prdata = 32'(block_bytes_ff);
         CSR_CHANNEL_COUNT: csr_prdata = 32'(channel_count_ff);
         CSR_VOLUME:        csr_prdata = 32'(volume_ff);
         default:           csr_prdata = '0;
      endcase
   end

   tadpcm_front #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .CH_W         (CH_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .block_bytes   (block_bytes_ff),
      .channel_count (channel_count_ff),
      .full          (q_full),
      .push          (q_push),
      .push_cmd      (push_cmd),
      .push_chan     (push_chan)
   );

   tadpcm_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_cmd, push_chan}),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_rd_data)
   );

   assign pop_cmd  = q_rd_data[QW-1:CH_W];
   assign pop_chan = q_rd_data[CH_W-1:0];

   tadpcm_back #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .CH_W         (CH_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (pop_cmd),
      .q_chan     (pop_chan),
      .q_pop      (q_pop),
      .coeff_a    (coeff_a_ff),
      .coeff_b    (coeff_b_ff),
      .volume     (volume_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> design/tadpcm_queue.sv
// small command queue between the front end and the decode engine
module tadpcm_queue #(
   parameter int WIDTH = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);
   import tadpcm_pkg::*;

   logic [WIDTH-1:0]  mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/tadpcm_front.sv
// front end: tracks block position, channel and scale, issues decode commands
module tadpcm_front #(
   parameter int MAX_CHANNELS = 2,
   parameter int CH_W         = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] data_byte
   input  logic [0:0]               req_tuser,   // [0] restart
   input  logic [7:0]               block_bytes,
   input  logic [1:0]               channel_count,
   input  logic                     full,
   output logic                     push,
   output tadpcm_pkg::cmd_type      push_cmd,
   output logic [CH_W-1:0]          push_chan
);
   import tadpcm_pkg::*;

   localparam int CNT_W = $clog2(MAX_CHANNELS + 1) + 2;

   logic [7:0]      pos_ff, pos_in;
   logic [CH_W-1:0] chan_ff, chan_in;
   logic [15:0]     scale_ff, scale_in;

   logic             accept;
   logic             restart;
   logic [7:0]       blen;
   logic [CNT_W-1:0] eff_chans;
   logic [7:0]       cur_pos;
   logic [CH_W-1:0]  raw_chan;
   logic [CH_W-1:0]  cur_chan;
   logic [7:0]       pos_next;
   logic             block_end;
   logic [CNT_W-1:0] chan_inc;
   logic [CH_W-1:0]  chan_next;

   assign req_tready = !full;
   assign accept     = req_tvalid && !full;
   assign restart    = req_tuser[0];

   // effective block length and channel count
   assign blen = (block_bytes < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : block_bytes;
   always_comb begin
      if (channel_count == 2'd0) begin
         eff_chans = CNT_W'(1);
      end else if (CNT_W'(channel_count) > CNT_W'(MAX_CHANNELS)) begin
         eff_chans = CNT_W'(MAX_CHANNELS);
      end else begin
         eff_chans = CNT_W'(channel_count);
      end
   end

   // position and channel for this word, restart and stale channel applied
   assign cur_pos   = restart ? POS_SCALE_HI : pos_ff;
   assign raw_chan  = restart ? '0 : chan_ff;
   assign cur_chan  = (CNT_W'(raw_chan) >= eff_chans) ? '0 : raw_chan;
   assign pos_next  = cur_pos + 8'd1;
   assign block_end = (pos_next >= blen) || (pos_next == 8'd0);
   assign chan_inc  = CNT_W'(cur_chan) + CNT_W'(1);
   assign chan_next = (chan_inc >= eff_chans) ? '0 : chan_inc[CH_W-1:0];

   // word classification and command issue
   always_comb begin
      pos_in             = pos_ff;
      chan_in            = chan_ff;
      scale_in           = scale_ff;
      push               = 1'b0;
      push_cmd.is_clear  = 1'b0;
      push_cmd.data_byte = req_tdata;
      push_cmd.scale     = scale_ff;
      push_chan          = cur_chan;
      if (accept) begin
         chan_in = cur_chan;
         case (cur_pos)
            POS_SCALE_HI: begin
               scale_in          = {req_tdata, scale_ff[7:0]};
               pos_in            = POS_SCALE_LO;
               push              = restart;
               push_cmd.is_clear = 1'b1;
            end
            POS_SCALE_LO: begin
               scale_in = {scale_ff[15:8], req_tdata};
               pos_in   = POS_FIRST_DATA;
            end
            default: begin
               push = 1'b1;
               if (block_end) begin
                  pos_in  = POS_SCALE_HI;
                  chan_in = chan_next;
               end else begin
                  pos_in = pos_next;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_SCALE_HI;
         chan_ff  <= '0;
         scale_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         chan_ff  <= chan_in;
         scale_ff <= scale_in;
      end
   end

endmodule

>>> design/tadpcm_back.sv
// decode engine: predictor, clamp, channel histories, volume and output register
module tadpcm_back #(
   parameter int MAX_CHANNELS = 2,
   parameter int CH_W         = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  tadpcm_pkg::cmd_type q_cmd,
   input  logic [CH_W-1:0]     q_chan,
   output logic                q_pop,
   input  logic [13:0]         coeff_a,
   input  logic [12:0]         coeff_b,
   input  logic [6:0]          volume,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // [15:0] sample
   output logic [0:0]          rsp_tuser,   // [0] channel
   output logic                rsp_tlast
);
   import tadpcm_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_SUM  = 5'b00100,
      ST_VOL  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic signed [15:0] hist_recent_ff [MAX_CHANNELS];
   logic signed [15:0] hist_recent_in [MAX_CHANNELS];
   logic signed [15:0] hist_older_ff  [MAX_CHANNELS];
   logic signed [15:0] hist_older_in  [MAX_CHANNELS];

   logic [7:0]         byte_ff, byte_in;
   logic [15:0]        scale_ff, scale_in;
   logic [CH_W-1:0]    ch_ff, ch_in;
   logic               nib_sel_ff, nib_sel_in;
   logic signed [30:0] pa_ff, pa_in;
   logic signed [28:0] pb_ff, pb_in;
   logic signed [20:0] pn_ff, pn_in;
   logic signed [15:0] s_ff, s_in;
   logic signed [23:0] vp_ff, vp_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_sample_ff, rsp_sample_in;
   logic               rsp_chan_ff, rsp_chan_in;
   logic               rsp_last_ff, rsp_last_in;

   logic signed [3:0]  nibble;
   logic signed [31:0] pred_sum;
   logic signed [31:0] total;
   logic               out_free;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_sample_ff;
   assign rsp_tuser[0] = rsp_chan_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign out_free     = !rsp_valid_ff || rsp_tready;

   // nibble pick, high nibble first
   assign nibble = nib_sel_ff ? $signed(byte_ff[3:0]) : $signed(byte_ff[7:4]);

   // prediction sum, floor shift and scaled nibble added
   assign pred_sum = 32'(pa_ff) + 32'(pb_ff);
   assign total    = (pred_sum >>> PRED_SHIFT) + 32'(pn_ff);

   always_comb begin
      state_in       = state_ff;
      hist_recent_in = hist_recent_ff;
      hist_older_in  = hist_older_ff;
      byte_in        = byte_ff;
      scale_in       = scale_ff;
      ch_in          = ch_ff;
      nib_sel_in     = nib_sel_ff;
      pa_in          = pa_ff;
      pb_in          = pb_ff;
      pn_in          = pn_ff;
      s_in           = s_ff;
      vp_in          = vp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_sample_in  = rsp_sample_ff;
      rsp_chan_in    = rsp_chan_ff;
      rsp_last_in    = rsp_last_ff;
      q_pop          = 1'b0;
      case (state_ff)
         // take the next command; a restart clears every channel's history
         ST_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               byte_in    = q_cmd.data_byte;
               scale_in   = q_cmd.scale;
               ch_in      = q_chan;
               nib_sel_in = 1'b0;
               if (q_cmd.is_clear) begin
                  for (int i = 0; i < MAX_CHANNELS; i++) begin
                     hist_recent_in[i] = '0;
                     hist_older_in[i]  = '0;
                  end
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         // predictor and scale products
         ST_MUL: begin
            pa_in    = 31'($signed({1'b0, coeff_a})) * 31'(hist_recent_ff[ch_ff]);
            pb_in    = 29'($signed(coeff_b)) * 29'(hist_older_ff[ch_ff]);
            pn_in    = 21'(nibble) * 21'($signed({1'b0, scale_ff}));
            state_in = ST_SUM;
         end
         // clamp to 16 bits and shift the channel history
         ST_SUM: begin
            if (total > SAMPLE_MAX) begin
               s_in = 16'sh7FFF;
            end else if (total < SAMPLE_MIN) begin
               s_in = -16'sh8000;
            end else begin
               s_in = total[15:0];
            end
            hist_older_in[ch_ff]  = hist_recent_ff[ch_ff];
            hist_recent_in[ch_ff] = s_in;
            state_in              = ST_VOL;
         end
         // volume product
         ST_VOL: begin
            vp_in    = 24'(s_ff) * 24'($signed({1'b0, volume}));
            state_in = ST_OUT;
         end
         // hand the sample to the output register
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = vp_ff[VOL_SHIFT +: 16];
               rsp_chan_in   = ch_ff[0];
               rsp_last_in   = nib_sel_ff;
               if (nib_sel_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  nib_sel_in = 1'b1;
                  state_in   = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and histories
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            hist_recent_ff[i] <= '0;
            hist_older_ff[i]  <= '0;
         end
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         hist_recent_ff <= hist_recent_in;
         hist_older_ff  <= hist_older_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      scale_ff      <= scale_in;
      ch_ff         <= ch_in;
      nib_sel_ff    <= nib_sel_in;
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      pn_ff         <= pn_in;
      s_ff          <= s_in;
      vp_ff         <= vp_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

>>> tb/sv/two_tap_adpcm_block_decoder_top_test.sv
// self-checking testbench for the two-tap adpcm block decoder top level
module two_tap_adpcm_block_decoder_top_test;
   import tadpcm_pkg::*;

   localparam int MAX_CH       = 2;
   localparam int QUIET_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int RAND_PHASES  = 13;

   // one expected sample word
   typedef struct {
      logic [15:0] sample;
      logic        channel;
      logic        last;
   } sample_word_type;

   // tracks decoder state and checks sample words in order
   class adpcm_scoreboard;
      logic [13:0]        coeff_a;
      logic signed [12:0] coeff_b;
      logic [7:0]         block_bytes;
      logic [1:0]         channel_count;
      logic [6:0]         volume;
      logic signed [15:0] recent_smp [MAX_CH];
      logic signed [15:0] older_smp  [MAX_CH];
      logic [15:0]        scale;
      logic [7:0]         position;
      int                 chan;
      sample_word_type    expected_words [$];
      int                 errors;

      function new();
         errors = 0;
         coeff_a       = COEFF_A_RST;
         coeff_b       = COEFF_B_RST;
         block_bytes   = BLOCK_BYTES_RST;
         channel_count = CHANNEL_COUNT_RST;
         volume        = VOLUME_RST;
         clear_history();
         scale    = '0;
         position = POS_SCALE_HI;
         chan     = 0;
      endfunction

      function void clear_history();
         foreach (recent_smp[i]) begin
            recent_smp[i] = '0;
            older_smp[i]  = '0;
         end
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            CSR_COEFF_A:       coeff_a       = value[13:0];
            CSR_COEFF_B:       coeff_b       = value[12:0];
            CSR_BLOCK_BYTES:   block_bytes   = value[7:0];
            CSR_CHANNEL_COUNT: channel_count = value[1:0];
            CSR_VOLUME:        volume        = value[6:0];
            default: ;
         endcase
      endfunction

      // block position the next word will see
      function int next_position(logic rs);
         return rs ? 0 : int'(position);
      endfunction

      // two-tap prediction plus scaled nibble, clamped to 16 bits
      function logic signed [15:0] decode_nibble(logic [3:0] nib, int ch);
         longint pred;
         longint s;
         pred = longint'(coeff_a) * longint'(recent_smp[ch])
              + longint'(coeff_b) * longint'(older_smp[ch]);
         s = longint'($signed(nib)) * longint'(scale) + (pred >>> PRED_SHIFT);
         if (s > SAMPLE_MAX) s = SAMPLE_MAX;
         else if (s < SAMPLE_MIN) s = SAMPLE_MIN;
         older_smp[ch]  = recent_smp[ch];
         recent_smp[ch] = s[15:0];
         return s[15:0];
      endfunction

      function logic [15:0] apply_volume(logic signed [15:0] s);
         longint v;
         v = (longint'(s) * longint'(volume)) >>> VOL_SHIFT;
         return v[15:0];
      endfunction

      function void push_word(logic signed [15:0] s, logic last);
         sample_word_type w;
         w.sample  = apply_volume(s);
         w.channel = chan[0];
         w.last    = last;
         expected_words.push_back(w);
      endfunction

      // note one accepted input word
      function void note_byte(logic [7:0] data_b, logic rs);
         int                 blen;
         int                 chans;
         logic signed [15:0] s_hi;
         logic signed [15:0] s_lo;
         blen  = (block_bytes < MIN_BLOCK_BYTES) ? int'(MIN_BLOCK_BYTES) : int'(block_bytes);
         chans = (channel_count < 1) ? 1 :
                 ((channel_count > MAX_CH) ? MAX_CH : int'(channel_count));
         if (rs) begin
            clear_history();
            position = POS_SCALE_HI;
            chan     = 0;
         end
         // channel count lowered while a later channel was current
         if (chan >= chans) chan = 0;
         if (position == POS_SCALE_HI) begin
            scale[15:8] = data_b;
            position    = POS_SCALE_LO;
         end else if (position == POS_SCALE_LO) begin
            scale[7:0] = data_b;
            position   = POS_FIRST_DATA;
         end else begin
            s_hi = decode_nibble(data_b[7:4], chan);
            s_lo = decode_nibble(data_b[3:0], chan);
            push_word(s_hi, 1'b0);
            push_word(s_lo, 1'b1);
            position = position + 8'd1;
            // block ends, also when the length was lowered mid-block
            if (position >= blen || position == 0) begin
               position = POS_SCALE_HI;
               chan++;
               if (chan >= chans) chan = 0;
            end
         end
      endfunction

      // compare one result word with the oldest expectation
      function void check_word(logic [15:0] sample, logic channel, logic last);
         sample_word_type w;
         if (expected_words.size() == 0) begin
            $error("unexpected sample word: sample %0h channel %0b last %0b",
                   sample, channel, last);
            errors++;
            return;
         end
         w = expected_words.pop_front();
         if (sample !== w.sample) begin
            $error("sample: expected %0d, got %0d", $signed(w.sample), $signed(sample));
            errors++;
         end
         if (channel !== w.channel) begin
            $error("channel: expected %0b, got %0b", w.channel, channel);
            errors++;
         end
         if (last !== w.last) begin
            $error("last: expected %0b, got %0b", w.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [7:0] data_byte
   logic [0:0]  req_tuser   = '0;   // [0] restart
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // [15:0] sample
   logic [0:0]  rsp_tuser;          // [0] channel
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr  = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   adpcm_scoreboard sb = new();
   bit  steady    = 1'b0;
   bit  hold_req  = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;
   int  cycle_count = 0;

   two_tap_adpcm_block_decoder_top #(.MAX_CHANNELS(MAX_CH)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("two_tap_adpcm_block_decoder_top_test: FAIL");
         $finish;
      end
   end

   // result side ready: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= 7);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_word(rsp_tdata, rsp_tuser[0], rsp_tlast);
      end
   end

   // one register write: setup then access
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
   endtask

   task automatic program_regs(input logic [13:0] a, input logic [12:0] b,
                               input logic [7:0] blk, input logic [1:0] ch,
                               input logic [6:0] vol);
      csr_write(CSR_COEFF_A, {18'd0, a});
      csr_write(CSR_COEFF_B, {19'd0, b});
      csr_write(CSR_BLOCK_BYTES, {24'd0, blk});
      csr_write(CSR_CHANNEL_COUNT, {30'd0, ch});
      csr_write(CSR_VOLUME, {25'd0, vol});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // offer one word and wait for it to be taken
   task automatic send_byte(input logic [7:0] data_b, input logic rs);
      if (!steady && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data_b;
      req_tuser  <= rs;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(data_b, rs);
   endtask

   // wait for all samples, then let any header word drain
   task automatic wait_drained();
      while (sb.pending() > 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // scale high bytes kept mostly small so samples do not always saturate
   function automatic logic [7:0] pick_byte(logic rs);
      int p;
      p = sb.next_position(rs);
      if (p == 0) begin
         case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(0, 3));
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic run_stream(input int count);
      logic rs;
      for (int i = 0; i < count; i++) begin
         rs = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) < 2);
         send_byte(pick_byte(rs), rs);
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      logic [13:0] a;
      logic [12:0] b;
      logic [7:0]  blk;
      logic [1:0]  ch;
      logic [6:0]  vol;
      int          count;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values, full and unit scale, nibble extremes
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h88, 1'b0);
      req_tvalid <= 1'b0;
      wait_drained();

      // largest coefficients, short block, channel count above the maximum
      program_regs(14'h3FFF, 13'h1000, 8'd0, 2'd3, 7'd127);
      send_byte(8'h00, 1'b1);
      send_byte(8'h40, 1'b0);
      send_byte(8'h77, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h99, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h7F, 1'b0);
      req_tvalid <= 1'b0;
      wait_drained();

      // stop mid-block on channel one, then shrink block and channel count
      program_regs(14'd4096, 13'd0, 8'd4, 2'd2, 7'd100);
      send_byte(8'h00, 1'b1);
      send_byte(8'h10, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h08, 1'b0);
      send_byte(8'h7E, 1'b0);
      req_tvalid <= 1'b0;
      wait_drained();
      program_regs(14'd4096, 13'd0, 8'd3, 2'd0, 7'd127);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'hC3, 1'b0);
      req_tvalid <= 1'b0;
      wait_drained();

      // random phases, register extremes first
      for (int p = 0; p < RAND_PHASES; p++) begin
         a     = ($urandom_range(0, 3) != 0) ? 14'($urandom_range(0, 8192))
                                             : 14'($urandom);
         b     = ($urandom_range(0, 3) != 0) ? 13'(-$urandom_range(0, 4096))
                                             : 13'($urandom);
         blk   = 8'($urandom_range(3, 24));
         ch    = 2'($urandom_range(0, 3));
         vol   = 7'($urandom_range(0, 127));
         count = 130;
         case (p)
            0: begin
               a = 14'd0; b = 13'd0; blk = 8'd255; ch = 2'd1; vol = 7'd127; count = 320;
            end
            1: begin
               a = 14'h3FFF; b = 13'h1000; blk = 8'd3; ch = 2'd2; vol = 7'd0;
            end
            2: begin
               a = 14'd8192; b = 13'h0FFF; blk = 8'd0; ch = 2'd3; vol = 7'd1;
            end
            3: begin
               blk = 8'd1; ch = 2'd0; vol = 7'd64;
            end
            4: steady = 1'b1;
            6: hold_req = 1'b1;
            default: begin
               if ($urandom_range(0, 9) == 0) blk = 8'($urandom_range(0, 2));
               else if ($urandom_range(0, 9) == 0) blk = 8'($urandom_range(25, 255));
            end
         endcase
         program_regs(a, b, blk, ch, vol);
         run_stream(count);
         wait_drained();
         steady = 1'b0;
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("two_tap_adpcm_block_decoder_top_test: PASS");
      end else begin
         $display("two_tap_adpcm_block_decoder_top_test: FAIL");
      end
      $finish;
   end

endmodule

>>> two_tap_adpcm_block_decoder_top.f
design/tadpcm_pkg.sv
design/tadpcm_queue.sv
design/tadpcm_front.sv
design/tadpcm_back.sv
design/two_tap_adpcm_block_decoder_top.sv
tb/sv/two_tap_adpcm_block_decoder_top_test.sv
